// ===== hdl/htf_pkg.sv =====
// Shared types and constants for the homogeneous point transform pipeline.
package htf_pkg;

    localparam int unsigned DW        = 32;  // Q16.16 word
    localparam int unsigned PW        = 64;  // full product
    localparam int unsigned SW        = 66;  // exact row sum
    localparam int unsigned WW        = 50;  // rounded wide Q16.16 row value
    localparam int unsigned QBITS     = 32;  // quotient bits, one per divide step
    localparam int unsigned NUM_CFG   = 8;
    localparam int unsigned CIW       = 4;   // config index width
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned NUM_STG   = QBITS + 4;

    localparam logic [WW-1:0] W_ONE   = WW'(65536);
    localparam logic [WW-1:0] W_ZERO  = '0;
    localparam logic [DW-1:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] Q_MIN   = 32'h8000_0000;

    // coefficient matrix: [row][col]
    typedef logic [3:0][3:0][DW-1:0] t_coef;

    typedef struct packed {
        logic [2:0][DW-1:0]   pt;
    } t_in_beat;

    typedef struct packed {
        logic [3:0][2:0][PW-1:0] prod;
        logic [3:0][DW-1:0]      c3;
    } t_prod_beat;

    typedef struct packed {
        logic [3:0][WW-1:0] w;
    } t_sum_beat;

    typedef struct packed {
        logic [2:0][WW-1:0] rem;
        logic [2:0][DW-1:0] lo;
        logic [WW-1:0]      den;
        logic [2:0]         neg;
        logic [2:0]         ovf;
        logic               div;
        logic [2:0][DW-1:0] clamp;
        logic               clamp_sat;
    } t_div_beat;

endpackage

// ===== hdl/htf_mul.sv =====
// Product stage: the twelve coefficient-by-coordinate products.
module htf_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ld,
    input  logic                  i_vld,
    input  htf_pkg::t_in_beat     i_beat,
    input  htf_pkg::t_coef        i_coef,
    output logic                  o_vld,
    output htf_pkg::t_prod_beat   o_beat
);
    import htf_pkg::*;

    logic       r_vld;
    t_prod_beat r_beat;
    t_prod_beat n_beat;

    // signed 32x32 products per row; column 3 is scaled later
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_beat.prod[r][c] = PW'($signed(i_coef[r][c]) * $signed(i_beat.pt[c]));
            end
            n_beat.c3[r] = i_coef[r][3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ld) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_beat <= n_beat;
        end
    end

    assign o_vld  = r_vld;
    assign o_beat = r_beat;
endmodule

// ===== hdl/htf_sum.sv =====
// Row sum stage: exact sum of products, rounded half up to wide Q16.16.
module htf_sum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ld,
    input  logic                  i_vld,
    input  htf_pkg::t_prod_beat   i_beat,
    output logic                  o_vld,
    output htf_pkg::t_sum_beat    o_beat
);
    import htf_pkg::*;

    logic       r_vld;
    t_sum_beat  r_beat;
    t_sum_beat  n_beat;
    logic signed [SW-1:0] s [4];

    // sum + half LSB, then floor by dropping 16 bits
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            s[r] = SW'($signed(i_beat.prod[r][0])) + SW'($signed(i_beat.prod[r][1]))
                 + SW'($signed(i_beat.prod[r][2]))
                 + (SW'($signed(i_beat.c3[r])) <<< 16)
                 + SW'(32768);
            n_beat.w[r] = s[r][SW-1:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ld) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_beat <= n_beat;
        end
    end

    assign o_vld  = r_vld;
    assign o_beat = r_beat;
endmodule

// ===== hdl/htf_prep.sv =====
// Divide setup: w test, magnitudes, overflow check and undivided clamp.
module htf_prep (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ld,
    input  logic                  i_vld,
    input  htf_pkg::t_sum_beat    i_beat,
    output logic                  o_vld,
    output htf_pkg::t_div_beat    o_beat
);
    import htf_pkg::*;

    logic          r_vld;
    t_div_beat     r_beat;
    t_div_beat     n_beat;
    logic [WW-1:0] abs_d;
    logic [WW-1:0] abs_n [3];
    logic [2:0]    hi;
    logic [2:0]    lo_sat;

    always_comb begin
        abs_d = i_beat.w[3][WW-1] ? WW'(-i_beat.w[3]) : i_beat.w[3];
        n_beat.den = abs_d;
        n_beat.div = (i_beat.w[3] != W_ONE) && (i_beat.w[3] != W_ZERO);
        for (int r = 0; r < 3; r++) begin
            abs_n[r] = i_beat.w[r][WW-1] ? WW'(-i_beat.w[r]) : i_beat.w[r];
            n_beat.neg[r] = i_beat.w[r][WW-1] ^ i_beat.w[3][WW-1];
            // integer part of the quotient must stay below 2^16
            n_beat.ovf[r] = WW'(abs_n[r][WW-1:16]) >= abs_d;
            n_beat.rem[r] = WW'(abs_n[r][WW-1:16]);
            n_beat.lo[r]  = {abs_n[r][15:0], 16'b0};
            // clamp for the undivided path
            hi[r]     = $signed(i_beat.w[r]) > $signed(WW'($signed(Q_MAX)));
            lo_sat[r] = $signed(i_beat.w[r]) < $signed(WW'($signed(Q_MIN)));
            if (hi[r]) begin
                n_beat.clamp[r] = Q_MAX;
            end else if (lo_sat[r]) begin
                n_beat.clamp[r] = Q_MIN;
            end else begin
                n_beat.clamp[r] = i_beat.w[r][DW-1:0];
            end
        end
        n_beat.clamp_sat = |(hi | lo_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ld) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_beat <= n_beat;
        end
    end

    assign o_vld  = r_vld;
    assign o_beat = r_beat;
endmodule

// ===== hdl/htf_div_step.sv =====
// One restoring divide step for all three lanes: one quotient bit each.
module htf_div_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ld,
    input  logic                  i_vld,
    input  htf_pkg::t_div_beat    i_beat,
    output logic                  o_vld,
    output htf_pkg::t_div_beat    o_beat
);
    import htf_pkg::*;

    logic          r_vld;
    t_div_beat     r_beat;
    t_div_beat     n_beat;
    logic [WW:0]   cand [3];
    logic [WW:0]   diff [3];
    logic [2:0]    ge;

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
        n_beat = i_beat;
        for (int r = 0; r < 3; r++) begin
            cand[r] = {i_beat.rem[r], i_beat.lo[r][DW-1]};
            diff[r] = cand[r] - {1'b0, i_beat.den};
            ge[r]   = cand[r] >= {1'b0, i_beat.den};
            n_beat.rem[r] = ge[r] ? diff[r][WW-1:0] : cand[r][WW-1:0];
            n_beat.lo[r]  = {i_beat.lo[r][DW-2:0], ge[r]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ld) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_beat <= n_beat;
        end
    end

    assign o_vld  = r_vld;
    assign o_beat = r_beat;
endmodule

// ===== hdl/homogeneous_point_transform_core.sv =====
// Pipeline: products, row sum, divide setup, 32 divide steps of one quotient bit
// each, output saturation register.
// Throughput: one point per cycle while the output is not stalled; each stage loads when it is empty or its
// successor loads, so bubbles close up while the output is stalled.
// Reset (synchronous, active low) clears all stage valid bits and loads the
// identity matrix.
module homogeneous_point_transform_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // config write port
    input  logic                      i_cfg_we,
    input  logic [htf_pkg::CIW-1:0]   i_cfg_idx,
    input  logic [htf_pkg::CFG_W-1:0] i_cfg_data,
    // input stream
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [95:0]               i_s_axis_tdata,  // in_x[31:0], in_y[63:32], in_z[95:64]
    // output stream
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [95:0]               o_m_axis_tdata,  // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [1:0]                o_m_axis_tuser   // divided[0], saturated[1]
);
    import htf_pkg::*;

    t_coef       r_coef;
    logic [NUM_STG-1:0] vld;
    logic [NUM_STG-1:0] ld;
    t_in_beat    in_beat;
    t_prod_beat  prod_beat;
    t_sum_beat   sum_beat;
    t_div_beat   div_beat [QBITS+1];

    logic        r_out_vld;
    logic [95:0] r_out_data;
    logic [1:0]  r_out_user;
    logic [95:0] n_out_data;
    logic [1:0]  n_out_user;
    logic [2:0]  lane_sat;

    // coefficient registers, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
            for (int k = 0; k < 4; k++) begin
                r_coef[k][k] <= DW'(65536);
            end
        end else if (i_cfg_we && (i_cfg_idx < CIW'(NUM_CFG))) begin
            r_coef[i_cfg_idx[2:1]][{i_cfg_idx[0], 1'b0}] <= i_cfg_data[DW-1:0];
            r_coef[i_cfg_idx[2:1]][{i_cfg_idx[0], 1'b1}] <= i_cfg_data[CFG_W-1:DW];
        end
    end

    // load enables ripple back from the output register
    assign ld[NUM_STG-1] = !vld[NUM_STG-1] || i_m_axis_tready;
    for (genvar k = 0; k < NUM_STG-1; k++) begin : g_ld
        assign ld[k] = !vld[k] || ld[k+1];
    end

    assign o_s_axis_tready = ld[0];
    assign in_beat.pt      = i_s_axis_tdata;

    htf_mul u_mul (
        .i_clk, .i_rst_n, .i_ld(ld[0]), .i_vld(i_s_axis_tvalid),
        .i_beat(in_beat), .i_coef(r_coef), .o_vld(vld[0]), .o_beat(prod_beat)
    );

    htf_sum u_sum (
        .i_clk, .i_rst_n, .i_ld(ld[1]), .i_vld(vld[0]),
        .i_beat(prod_beat), .o_vld(vld[1]), .o_beat(sum_beat)
    );

    htf_prep u_prep (
        .i_clk, .i_rst_n, .i_ld(ld[2]), .i_vld(vld[1]),
        .i_beat(sum_beat), .o_vld(vld[2]), .o_beat(div_beat[0])
    );

    for (genvar k = 0; k < QBITS; k++) begin : g_div
        htf_div_step u_step (
            .i_clk, .i_rst_n, .i_ld(ld[k+3]), .i_vld(vld[k+2]),
            .i_beat(div_beat[k]), .o_vld(vld[k+3]), .o_beat(div_beat[k+1])
        );
    end

    // sign, saturation and path select
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            lane_sat[r] = 1'b0;
            n_out_data[r*DW +: DW] = div_beat[QBITS].clamp[r];
            if (div_beat[QBITS].div) begin
                if (div_beat[QBITS].ovf[r]) begin
                    lane_sat[r] = 1'b1;
                    n_out_data[r*DW +: DW] = div_beat[QBITS].neg[r] ? Q_MIN : Q_MAX;
                end else if (div_beat[QBITS].neg[r]) begin
                    if (div_beat[QBITS].lo[r] > Q_MIN) begin
                        lane_sat[r] = 1'b1;
                        n_out_data[r*DW +: DW] = Q_MIN;
                    end else begin
                        n_out_data[r*DW +: DW] = DW'(-div_beat[QBITS].lo[r]);
                    end
                end else if (div_beat[QBITS].lo[r] > Q_MAX) begin
                    lane_sat[r] = 1'b1;
                    n_out_data[r*DW +: DW] = Q_MAX;
                end else begin
                    n_out_data[r*DW +: DW] = div_beat[QBITS].lo[r];
                end
            end
        end
        n_out_user[0] = div_beat[QBITS].div;
        n_out_user[1] = div_beat[QBITS].div ? (|lane_sat) : div_beat[QBITS].clamp_sat;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ld[NUM_STG-1]) begin
            r_out_vld <= vld[NUM_STG-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[NUM_STG-1]) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign vld[NUM_STG-1]  = r_out_vld;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
endmodule

// ===== bench/htf_checker.sv =====
// Scoreboard for the point transform: predicts each output beat and compares it.
module htf_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [htf_pkg::CIW-1:0]   i_cfg_idx,
    input  logic [htf_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_s_axis_tvalid,
    input  logic                      i_s_axis_tready,
    input  logic [95:0]               i_s_axis_tdata,
    input  logic                      i_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    input  logic [95:0]               i_m_axis_tdata,
    input  logic [1:0]                i_m_axis_tuser,
    output int                        o_errors,
    output int                        o_pending
);
    import htf_pkg::*;

    typedef struct packed {
        logic [2:0][DW-1:0] xyz;
        logic               divided;
        logic               saturated;
    } t_point_out;

    logic [NUM_CFG-1:0][CFG_W-1:0] matrix_regs;
    t_point_out                    point_q[$];

    // exact row sum, rounded half up to wide Q16.16
    function automatic longint row_value(logic [CFG_W-1:0] c01, logic [CFG_W-1:0] c23,
                                         logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
        logic signed [95:0] acc;
        acc = 96'(signed'(c01[31:0])) * 96'(x) + 96'(signed'(c01[63:32])) * 96'(y)
            + 96'(signed'(c23[31:0])) * 96'(z) + (96'(signed'(c23[63:32])) <<< 16);
        acc = (acc + 96'sh8000) >>> 16;
        return longint'(acc);
    endfunction

    function automatic logic [31:0] clamp_q(longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // (n << 16) / d, truncated toward zero, then saturated
    function automatic logic [31:0] divide_q(longint n, longint d, inout logic sat);
        logic signed [95:0] q;
        q = (96'(n) <<< 16) / 96'(d);
        if (q > 96'sd2147483647) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (q < -96'sd2147483648) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return q[31:0];
    endfunction

    function automatic t_point_out transform_point(logic [95:0] pt);
        t_point_out r;
        longint     rows [4];
        logic       sat;
        sat = 1'b0;
        for (int i = 0; i < 4; i++)
            rows[i] = row_value(matrix_regs[2*i], matrix_regs[2*i+1],
                                pt[31:0], pt[63:32], pt[95:64]);
        r.divided = (rows[3] != 65536) && (rows[3] != 0);
        for (int i = 0; i < 3; i++)
            r.xyz[i] = r.divided ? divide_q(rows[i], rows[3], sat) : clamp_q(rows[i], sat);
        r.saturated = sat;
        return r;
    endfunction

    assign o_pending = point_q.size();

    always @(posedge i_clk) begin
        t_point_out want;
        if (!i_rst_n) begin
            matrix_regs[0] <= 64'd65536;
            matrix_regs[1] <= 64'd0;
            matrix_regs[2] <= 64'd65536 << 32;
            matrix_regs[3] <= 64'd0;
            matrix_regs[4] <= 64'd0;
            matrix_regs[5] <= 64'd65536;
            matrix_regs[6] <= 64'd0;
            matrix_regs[7] <= 64'd65536 << 32;
            o_errors       <= 0;
            point_q.delete();
        end else begin
            if (i_cfg_we && i_cfg_idx < NUM_CFG)
                matrix_regs[i_cfg_idx[2:0]] <= i_cfg_data;
            if (i_s_axis_tvalid && i_s_axis_tready)
                point_q.push_back(transform_point(i_s_axis_tdata));
            // output side
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (point_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected output beat %h", i_m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    want = point_q.pop_front();
                    if (want.xyz != i_m_axis_tdata ||
                        want.divided != i_m_axis_tuser[0] ||
                        want.saturated != i_m_axis_tuser[1]) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %h div %b sat %b, got %h user %b",
                                     want.xyz, want.divided, want.saturated,
                                     i_m_axis_tdata, i_m_axis_tuser);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== bench/tb.sv =====
// Testbench top: drives points and matrix writes into the transform core.
module tb;
    import htf_pkg::*;

    localparam int LIMIT = 400000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CIW-1:0]   cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [95:0]      in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [95:0]      out_data;
    logic [1:0]       out_user;
    int               errors;
    int               pending;
    int               cycles = 0;
    bit               hold_long = 1'b0;

    always #5 i_clk = ~i_clk;

    homogeneous_point_transform_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(in_valid), .o_s_axis_tready(in_ready), .i_s_axis_tdata(in_data),
        .o_m_axis_tvalid(out_valid), .i_m_axis_tready(out_ready),
        .o_m_axis_tdata(out_data), .o_m_axis_tuser(out_user)
    );

    htf_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(in_valid), .i_s_axis_tready(in_ready), .i_s_axis_tdata(in_data),
        .i_m_axis_tvalid(out_valid), .i_m_axis_tready(out_ready),
        .i_m_axis_tdata(out_data), .i_m_axis_tuser(out_user),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // coordinate: mostly moderate values, sometimes extremes or raw bits
    function automatic logic [31:0] coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic logic [31:0] coef();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h0001_0000;
            2: return 32'h0;
            default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_long)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(9) < 7);
    end

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int g;
        g = gap_len();
        repeat (g) begin
            @(posedge i_clk);
            in_valid <= 1'b0;
        end
        @(posedge i_clk);
        in_valid <= 1'b1;
        in_data  <= {z, y, x};
        do @(posedge i_clk); while (!in_ready);
        in_valid <= 1'b0;
    endtask

    // keeps valid up across beats (no gaps) for back-to-back traffic
    task automatic burst_points(int n);
        @(posedge i_clk);
        in_valid <= 1'b1;
        in_data  <= {coord(), coord(), coord()};
        for (int i = 1; i < n; i++) begin
            do @(posedge i_clk); while (!in_ready);
            in_data <= {coord(), coord(), coord()};
        end
        do @(posedge i_clk); while (!in_ready);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CIW'(idx);
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity matrix: extremes, zero, w path untouched
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA);
        drain();

        // w = 2 (divide), large coefficients to saturate
        write_reg(7, {32'h0002_0000, 32'h0});
        write_reg(0, {32'h0, 32'h7FFF_FFFF});
        send_point(32'h7FFF_FFFF, 32'h1, 32'h2);
        send_point(32'h0003_0000, 32'hFFFF_0000, 32'h0);
        drain();

        // w from z: w = 0, w = 1, tiny w, negative w
        write_reg(6, 64'h0);
        write_reg(7, {32'h0, 32'h0001_0000});
        write_reg(0, {32'h0, 32'h0001_0000});
        send_point(32'h1234_0000, 32'h1, 32'h0);
        send_point(32'h1234_0000, 32'h1, 32'h0001_0000);
        send_point(32'h1234_0000, 32'h1, 32'h0000_0001);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
        send_point(32'h0000_8000, 32'h0, 32'h8000_0000);
        send_point(32'h0, 32'h0, 32'h7FFF_FFFF);
        drain();
        // out-of-range index is ignored
        write_reg(12, 64'hFFFF_FFFF_FFFF_FFFF);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        drain();

        // random matrices, last one extreme; one long receiver hold-off
        for (int ph = 0; ph < 12; ph++) begin
            for (int r = 0; r < NUM_CFG; r++) begin
                if (ph == 11)
                    write_reg(r, (r == 0 || r == 5) ? 64'hFFFF_FFFF_8000_0000
                                                    : 64'h7FFF_FFFF_7FFF_FFFF);
                else if (ph % 3 != 0 || r < 6)
                    write_reg(r, {coef(), coef()});
                else
                    write_reg(r, r == 6 ? 64'h0 : {32'h0001_0000, 32'h0});
            end
            if (ph == 4) begin
                fork
                    begin
                        hold_long = 1'b1;
                        repeat (200) @(posedge i_clk);
                        hold_long = 1'b0;
                    end
                    burst_points(80);
                join
            end
            for (int i = 0; i < 45; i++) begin
                if ($urandom_range(4) == 0)
                    burst_points($urandom_range(12, 2));
                else
                    send_point(coord(), coord(), coord());
            end
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
